### src/snorcs_pkg.sv
// Shared types, constants and the part ID table for the SPI NOR command splitter.
// No dependencies; every other file imports this package.
package snorcs_pkg;

  localparam int ADDR_W  = 24;
  localparam int LEN_W   = 13;
  localparam int SIZE_W  = 22;
  localparam int MAX_RES = 17;
  localparam int CNT_W   = 5;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 72;

  localparam logic [7:0] OPC_READ    = 8'h03;
  localparam logic [7:0] OPC_PROGRAM = 8'h02;
  localparam logic [7:0] OPC_ERASE   = 8'h20;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_PROGRAM  = 2'd1,
    OP_ERASE    = 2'd2,
    OP_IDENTIFY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_COMMAND = 2'd0,
    KIND_NOTHING = 2'd1,
    KIND_KNOWN   = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MODE_SINGLE  = 2'd0,
    MODE_PROGRAM = 2'd1,
    MODE_ERASE   = 2'd2
  } mode_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         opcode;
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   bytes;
    logic               wen;
    logic [SIZE_W-1:0]  size;
    logic               last;
  } result_t;

  // One classified request as it waits between front and back
  typedef struct packed {
    mode_e              mode;
    result_t            res;   // complete result for single-result requests
    logic [ADDR_W-1:0]  addr;  // program start or first sector base
    logic [LEN_W-1:0]   len;   // saturated program length
    logic [CNT_W-1:0]   cnt;   // sector count, already clamped
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } q_out_t;

  function automatic logic [SIZE_W-1:0] part_size(input logic [7:0] manf,
                                                  input logic [7:0] dev);
    logic [SIZE_W-1:0] size;
    size = '0;
    if (manf == 8'hC2 && dev == 8'h15) size = SIZE_W'(32'h200000);
    else if (manf == 8'hC2 && dev == 8'h14) size = SIZE_W'(32'h100000);
    else if (manf == 8'hEF && dev == 8'h12) size = SIZE_W'(32'h080000);
    else if (manf == 8'hEF && dev == 8'h11) size = SIZE_W'(32'h040000);
    return size;
  endfunction

endpackage

### src/snorcs_front.sv
// Front end: classifies one request into a queue descriptor.
// Depends on snorcs_pkg.
module snorcs_front #(
  parameter int SECTOR_BYTES      = 4096,
  parameter int MAX_REQUEST_BYTES = 4096
) (
  input  logic [1:0]                      operation_i,
  input  logic [snorcs_pkg::ADDR_W-1:0]   start_offset_i,
  input  logic [snorcs_pkg::LEN_W-1:0]    request_length_i,
  input  logic [7:0]                      manufacturer_id_i,
  input  logic [7:0]                      device_id_i,
  output snorcs_pkg::desc_t               desc_o
);
  import snorcs_pkg::*;

  localparam int SEC_SH = $clog2(SECTOR_BYTES);
  localparam int SPAN_W = ADDR_W + 1;

  logic [LEN_W-1:0]  len_sat;
  logic [SPAN_W-1:0] span;
  logic [SPAN_W-1:0] sectors;
  logic [CNT_W-1:0]  cnt;
  logic [SIZE_W-1:0] size;

  always_comb begin
    if (32'(request_length_i) > 32'(MAX_REQUEST_BYTES)) begin
      len_sat = LEN_W'(MAX_REQUEST_BYTES);
    end else begin
      len_sat = request_length_i;
    end
  end

  // offset within its sector plus length minus one, then whole sectors past the first
  assign span    = SPAN_W'(start_offset_i & ADDR_W'(SECTOR_BYTES - 1))
                 + SPAN_W'(len_sat) - SPAN_W'(1);
  assign sectors = span >> SEC_SH;
  assign cnt     = (sectors >= SPAN_W'(MAX_RES - 1)) ? CNT_W'(MAX_RES)
                                                    : CNT_W'(sectors) + CNT_W'(1);
  assign size    = part_size(manufacturer_id_i, device_id_i);

  always_comb begin
    desc_o       = '0;
    desc_o.mode  = MODE_SINGLE;
    desc_o.res.last = 1'b1;
    desc_o.len   = len_sat;
    desc_o.cnt   = cnt;
    if (operation_i == OP_IDENTIFY) begin
      desc_o.res.kind = (size != '0) ? KIND_KNOWN : KIND_UNKNOWN;
      desc_o.res.size = size;
    end else if (len_sat == '0) begin
      desc_o.res.kind = KIND_NOTHING;
    end else if (operation_i == OP_READ) begin
      desc_o.res.kind   = KIND_COMMAND;
      desc_o.res.opcode = OPC_READ;
      desc_o.res.addr   = start_offset_i;
      desc_o.res.bytes  = len_sat;
    end else if (operation_i == OP_PROGRAM) begin
      desc_o.mode = MODE_PROGRAM;
      desc_o.addr = start_offset_i;
    end else begin
      desc_o.mode = MODE_ERASE;
      desc_o.addr = start_offset_i & ~ADDR_W'(SECTOR_BYTES - 1);
    end
  end

endmodule

### src/snorcs_queue.sv
// Two-entry descriptor queue between front and back.
// Depends on snorcs_pkg.
module snorcs_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  snorcs_pkg::desc_t   desc_i,
  output logic                full_o,
  input  logic                pop_i,
  output snorcs_pkg::q_out_t  head_o
);
  import snorcs_pkg::*;

  desc_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o      = (cnt_q == 2'd2);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.desc  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + 1'b1;
    rd_ptr_d = rd_ptr_q + 1'b1;
    if (!push_i) wr_ptr_d = wr_ptr_q;
    if (!pop_i)  rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### src/snorcs_back.sv
// Back end: walks one descriptor into result items, one per cycle unless the output stalls, into an output register.
// Depends on snorcs_pkg.
module snorcs_back #(
  parameter int PAGE_BYTES   = 256,
  parameter int SECTOR_BYTES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  snorcs_pkg::q_out_t  head_i,
  output logic                pop_o,
  output snorcs_pkg::result_t res_o,
  output logic                valid_o,
  input  logic                ready_i
);
  import snorcs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  result_t           out_q, out_d;
  logic              out_v_q, out_v_d;

  logic              slot_free;
  logic [LEN_W-1:0]  pg_off, room, piece;
  result_t           step_res;

  assign slot_free = !out_v_q || ready_i;
  assign res_o     = out_q;
  assign valid_o   = out_v_q;

  assign pg_off = LEN_W'(addr_q & ADDR_W'(PAGE_BYTES - 1));
  assign room   = LEN_W'(PAGE_BYTES) - pg_off;
  assign piece  = (left_q < room) ? left_q : room;

  always_comb begin
    step_res      = '0;
    step_res.kind = KIND_COMMAND;
    step_res.addr = addr_q;
    step_res.wen  = 1'b1;
    if (mode_q == MODE_PROGRAM) begin
      step_res.opcode = OPC_PROGRAM;
      step_res.bytes  = piece;
      step_res.last   = (left_q == piece) || (idx_q == CNT_W'(MAX_RES - 1));
    end else begin
      step_res.opcode = OPC_ERASE;
      step_res.last   = (idx_q + CNT_W'(1) == cnt_q);
    end
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    addr_d  = addr_q;
    left_d  = left_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    out_d   = out_q;
    out_v_d = out_v_q && !ready_i;
    pop_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid && slot_free) begin
          pop_o  = 1'b1;
          mode_d = head_i.desc.mode;
          addr_d = head_i.desc.addr;
          left_d = head_i.desc.len;
          cnt_d  = head_i.desc.cnt;
          idx_d  = '0;
          if (head_i.desc.mode == MODE_PROGRAM || head_i.desc.mode == MODE_ERASE) begin
            state_d = ST_RUN;
          end else begin
            out_d   = head_i.desc.res;
            out_v_d = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          out_d   = step_res;
          out_v_d = 1'b1;
          idx_d   = idx_q + CNT_W'(1);
          if (mode_q == MODE_PROGRAM) begin
            left_d = left_q - piece;
            addr_d = addr_q + ADDR_W'(piece);
          end else begin
            addr_d = addr_q + ADDR_W'(SECTOR_BYTES);
          end
          if (step_res.last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    addr_q <= addr_d;
    left_q <= left_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
    end
  end

endmodule

### src/spi_nor_command_splitter_top.sv
// SPI NOR command splitter: turns host flash requests into NOR command items.
// Depends on snorcs_pkg, snorcs_front, snorcs_queue, snorcs_back.
//
// Input channel s_axis: one request per item, operation in tuser.
// Output channel m_axis: command descriptors, result kind in tuser, tlast on
// the final item of each request.
// Read, identify and zero-length requests give one item; a program gives one
// item per page piece, an erase one item per sector touched, at most 17.
// When the back end is free, a single-item request passes through the queue and
// the output register; the first item of a multi-item request also waits for
// the back end to take the request off the queue and enter its run state. It
// then emits one item per cycle while the output is not stalled, and takes the
// next request off the queue only after the final item of this one.
// A two-entry queue lets requests be accepted while the back end works or the
// receiver stalls; s_axis_tready drops only when the queue is full.
// A stalled output item holds in the output register until taken.
// Reset empties the queue and the output register and returns the back end to idle.
// PAGE_BYTES and SECTOR_BYTES must be powers of two; the block itself does not enforce this.
module spi_nor_command_splitter_top #(
  parameter int PAGE_BYTES        = 256,
  parameter int SECTOR_BYTES      = 4096,
  parameter int MAX_REQUEST_BYTES = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // start_offset[23:0], request_length[36:24], manufacturer_id[44:37],
  // device_id[52:45], zero fill
  input  logic [snorcs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // command_opcode[7:0], flash_address[31:8], transfer_bytes[44:32],
  // needs_write_enable[45], part_size_bytes[67:46], zero fill
  output logic [snorcs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // result_kind[1:0]
  output logic [1:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);
  import snorcs_pkg::*;

  desc_t   desc;
  q_out_t  head;
  logic    q_full;
  logic    push;
  logic    pop;
  result_t res;

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  snorcs_front #(
    .SECTOR_BYTES      (SECTOR_BYTES),
    .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
  ) u_front (
    .operation_i       (s_axis_tuser),
    .start_offset_i    (s_axis_tdata[23:0]),
    .request_length_i  (s_axis_tdata[36:24]),
    .manufacturer_id_i (s_axis_tdata[44:37]),
    .device_id_i       (s_axis_tdata[52:45]),
    .desc_o            (desc)
  );

  snorcs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (desc),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  snorcs_back #(
    .PAGE_BYTES   (PAGE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .pop_o   (pop),
    .res_o   (res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {4'b0, res.size, res.wen, res.bytes, res.addr, res.opcode};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

### src/snorcs_checker.sv
// Port-level assertions for the SPI NOR command splitter, bound to the top level.
// Depends on snorcs_pkg and spi_nor_command_splitter_top.
module snorcs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [snorcs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [1:0]                          m_axis_tuser,
  input logic                                m_axis_tlast
);
  import snorcs_pkg::*;

  // output register is cleared by reset
  a_idle_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled output item changed");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_COMMAND
      || m_axis_tdata[7:0] == OPC_READ) |-> m_axis_tlast)
    else $error("single-item result without tlast");

  a_erase_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_COMMAND && m_axis_tdata[7:0] == OPC_ERASE
      |-> m_axis_tdata[45] && m_axis_tdata[44:32] == '0)
    else $error("erase item with data bytes or without write enable");

  a_program_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_COMMAND && m_axis_tdata[7:0] == OPC_PROGRAM
      |-> m_axis_tdata[45] && m_axis_tdata[44:32] != '0)
    else $error("program item with no bytes or without write enable");

endmodule

bind spi_nor_command_splitter_top snorcs_checker u_snorcs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
